[rtl/core/tree_plru_replacement_top_defines.svh]
// assertion macros shared by the tree plru replacement rtl
// no dependencies; included by modules that carry assertions
`ifndef TREE_PLRU_REPLACEMENT_TOP_DEFINES_SVH
`define TREE_PLRU_REPLACEMENT_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TPLRU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TPLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tplru_pkg.sv]
// types and constants of the tree plru replacement block
// no dependencies; imported by the top, controller and datapath modules of the block
`timescale 1ns / 1ps
`default_nettype none

package tplru_pkg;

    localparam int ADDR_W     = 16;
    localparam int WAY_W      = 5;
    localparam int WORD_W     = 31;
    localparam int WL_W       = 3;
    localparam int OFS_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_WAYS   = 32;
    localparam int MAX_LEVELS = 5;
    localparam int WAY_CAP_RAW = $clog2(MAX_WAYS + 1) - 1;
    localparam int WAY_CAP    = (WAY_CAP_RAW > MAX_LEVELS) ? MAX_LEVELS : WAY_CAP_RAW;

    localparam logic [WL_W-1:0]   WAYS_LOG2_RST   = 3'd2;
    localparam logic [OFS_W-1:0]  OFFSET_BITS_RST = 4'd4;
    localparam logic [ADDR_W-1:0] INDEX_MASK_RST  = 16'd4080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAYS_LOG2   = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_INDEX_MASK  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_FIND   = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef struct packed {
        op_t               operation;
        logic [ADDR_W-1:0] address;
        logic [WAY_W-1:0]  way;
    } request_t;

    typedef struct packed {
        logic [WAY_W-1:0]  victim_way;
        logic [WORD_W-1:0] tree_bits;
    } result_t;

    typedef struct packed {
        logic capture;
        logic reduce;
        logic read;
        logic exec;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic need_reduce;
        logic reduce_last;
        logic clear_last;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/tree_plru_replacement_top.sv]
// result path: from the accepting edge the controller passes through the restoring steps of
// the set index reduction (only when SETS is not a power of two), then the read and exec states
// a new request is taken only in idle, after the table read and write-back of the last one
// reset: after rst_n release busy stays high while every set of the table is swept to zero
// the receiver cannot stall; each result is shown for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module tree_plru_replacement_top #(
    parameter int SETS = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire tplru_pkg::request_t              request,
    output logic                                  done,
    output tplru_pkg::result_t                    result,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tplru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tplru_pkg::CFG_DATA_W-1:0] cfg_data
);

    import tplru_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tplru_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    tplru_datapath #(
        .SETS (SETS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

`default_nettype wire

[rtl/core/tplru_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tplru_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/tplru_datapath.sv]
// datapath: config registers, set index reduction, tree table and tree walk
// depends on tplru_pkg and tplru_ram
`timescale 1ns / 1ps
`default_nettype none

module tplru_datapath #(
    parameter int SETS = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tplru_pkg::request_t              request,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tplru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tplru_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire tplru_pkg::dp_cmd_t               cmd,
    output tplru_pkg::dp_status_t                 status,
    output tplru_pkg::result_t                    result
);

    import tplru_pkg::*;

    localparam int IDX_W      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam bit NEED_RED   = (SETS & (SETS - 1)) != 0;
    localparam int MAX_Q      = 65535 / SETS;
    localparam int RED_STEPS  = (MAX_Q > 0) ? $clog2(MAX_Q + 1) : 1;
    localparam logic [ADDR_W:0] DIV_BASE = (ADDR_W + 1)'(SETS);
    localparam logic [ADDR_W:0] DIV_INIT = DIV_BASE << (RED_STEPS - 1);
    localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'(SETS - 1);
    localparam logic [IDX_W-1:0]  LAST_SET = IDX_W'(SETS - 1);
    localparam logic [WL_W-1:0]   WAY_CAP_L = WL_W'(WAY_CAP);

    logic [WL_W-1:0]   ways_log2_reg;
    logic [OFS_W-1:0]  offset_bits_reg;
    logic [ADDR_W-1:0] index_mask_reg;

    request_t          req_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [ADDR_W:0]   div_reg;
    logic [ADDR_W:0]   div_next;
    logic [IDX_W-1:0]  clr_addr_reg;
    result_t           result_reg;

    logic [ADDR_W-1:0] idx_eff;
    logic [IDX_W-1:0]  set_idx;
    logic [WL_W-1:0]   wl_eff;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] new_word;
    logic [WAY_W-1:0]  victim;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_log2_reg   <= WAYS_LOG2_RST;
            offset_bits_reg <= OFFSET_BITS_RST;
            index_mask_reg  <= INDEX_MASK_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_WAYS_LOG2:   ways_log2_reg   <= cfg_data[WL_W-1:0];
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[OFS_W-1:0];
                CFG_INDEX_MASK:  index_mask_reg  <= cfg_data[ADDR_W-1:0];
                default:         ;
            endcase
        end
    end

    // set index: mask, shift, then restoring reduction modulo sets (a plain mask when sets is a power of two)
    always_comb
    begin
        idx_next = idx_reg;
        div_next = div_reg;
        if (cmd.capture)
        begin
            idx_next = (request.address & index_mask_reg) >> offset_bits_reg;
            div_next = DIV_INIT;
        end
        else if (cmd.reduce)
        begin
            if ({1'b0, idx_reg} >= div_reg)
            begin
                idx_next = ADDR_W'({1'b0, idx_reg} - div_reg);
            end
            div_next = div_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        div_reg <= div_next;
        if (cmd.capture)
        begin
            req_reg <= request;
        end
    end

    assign idx_eff = NEED_RED ? idx_reg : (idx_reg & SET_MASK);
    assign set_idx = idx_eff[IDX_W-1:0];

    // clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
        end
    end

    assign status.need_reduce = NEED_RED;
    assign status.reduce_last = !NEED_RED || (div_reg == DIV_BASE);
    assign status.clear_last  = (clr_addr_reg == LAST_SET);

    // tree walk over at most five levels
    assign wl_eff = (ways_log2_reg > WAY_CAP_L) ? WAY_CAP_L : ways_log2_reg;

    always_comb
    begin
        logic [WAY_W-1:0] node;
        logic [WAY_W-1:0] rem;
        logic [WAY_W-1:0] half;
        node     = '0;
        rem      = req_reg.way;
        half     = '0;
        victim   = '0;
        new_word = rd_word;
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            if (WL_W'(l) < wl_eff)
            begin
                half = WAY_W'(1) << (wl_eff - WL_W'(l) - WL_W'(1));
                if (req_reg.operation == OP_FIND)
                begin
                    if (!rd_word[node])
                    begin
                        victim = victim + half;
                        node   = node + half;
                    end
                    else
                    begin
                        node = node + WAY_W'(1);
                    end
                end
                else
                begin
                    if (rem >= half)
                    begin
                        new_word[node] = 1'b1;
                        node           = node + half;
                        rem            = rem - half;
                    end
                    else
                    begin
                        new_word[node] = 1'b0;
                        node           = node + WAY_W'(1);
                    end
                end
            end
        end
    end

    // table write: clearing sweep or update write-back
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = set_idx;
        ram_wdata = new_word;
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (cmd.exec && req_reg.operation == OP_UPDATE)
        begin
            ram_we = 1'b1;
        end
    end

    tplru_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SETS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (set_idx),
        .rdata (rd_word)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            result_reg.victim_way <= (req_reg.operation == OP_FIND) ? victim : '0;
            result_reg.tree_bits  <= new_word;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/core/tplru_ctrl.sv]
// controller state machine: table clearing, index reduction, read, execute
// depends on tplru_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "tree_plru_replacement_top_defines.svh"

module tplru_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    output logic                       done,
    output tplru_pkg::dp_cmd_t         cmd,
    input  wire tplru_pkg::dp_status_t status
);

    import tplru_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = status.need_reduce ? ST_REDUCE : ST_READ;
                end
            end
            ST_REDUCE:
            begin
                if (status.reduce_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EXEC);
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.capture = (state_reg == ST_IDLE) && start;
        cmd.reduce  = (state_reg == ST_REDUCE);
        cmd.read    = (state_reg == ST_READ);
        cmd.exec    = (state_reg == ST_EXEC);
        cmd.clear   = (state_reg == ST_CLEAR);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    `TPLRU_ASSERT_NEXT(a_done_single_beat, clk, rst_n, done_reg, !done_reg, "done longer than one beat")
    `TPLRU_ASSERT_NEXT(a_exec_then_done, clk, rst_n, state_reg == ST_EXEC, done_reg && state_reg == ST_IDLE, "exec not followed by result")
    `TPLRU_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy, "accepted beat did not raise busy")
    `TPLRU_ASSERT_NOW(a_no_done_in_clear, clk, rst_n, state_reg == ST_CLEAR, !done_reg, "result during table clear")

endmodule

`default_nettype wire
